// ===== rtl/kprng_pkg.sv =====
package kprng_pkg;

	localparam int unsigned TBL_DEPTH = 256;
	localparam int unsigned TBL_AW    = 8;
	localparam int unsigned WORD_W    = 32;

	localparam logic [WORD_W-1:0] L_MUL = 32'h9e37_79b7;
	localparam logic [WORD_W-1:0] M_MUL = 32'h06a0_dd9b;

	localparam logic [TBL_AW-1:0] STEP_FIRST = 8'd255;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_NEXT  = 1'b1;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_FILL0  = 12'b0000_0000_0010,
		ST_FILL   = 12'b0000_0000_0100,
		ST_RD6    = 12'b0000_0000_1000,
		ST_RD7    = 12'b0000_0001_0000,
		ST_MIX    = 12'b0000_0010_0000,
		ST_WORD   = 12'b0000_0100_0000,
		ST_SWAP   = 12'b0000_1000_0000,
		ST_SWAP2  = 12'b0001_0000_0000,
		ST_RSEED  = 12'b0010_0000_0000,
		ST_RSLAST = 12'b0100_0000_0000,
		ST_OUT    = 12'b1000_0000_0000
	} state_t;

	// rotate left; amount zero passes the operand through
	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
			input logic [4:0] amt);
		logic [2*WORD_W-1:0] t;
		t = {v, v} << amt;
		return t[2*WORD_W-1:WORD_W];
	endfunction

endpackage

// ===== rtl/keyed_permutation_prng_stream.sv =====
// channel  | dir | tdata                                  | tuser
// s_axis   | in  | [31:0] key                             | [0] cmd
// m_axis   | out | [31:0] word, [63:32] round_constant    | [0] word_valid
//
// A next word runs RD6, RD7, MIX, WORD, SWAP and SWAP2 after accept: sequenced M reads,
// the L read at the new low byte and the L swap over SWAP and SWAP2.
// Every 255th word adds an M ^= L pass over all 256 entries (one entry a cycle).
// A start runs FILL0 (one multiply per table), then FILL (one table row a cycle), then OUT.
// Reset clears control and stream state; the tables are only read after a start.
// s_axis_tready is high in idle; a waiting result does not block the next accept.
module keyed_permutation_prng_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] key
	input  logic        s_axis_tuser,   // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] word, [63:32] round_constant
	output logic        m_axis_tuser    // [0] word_valid
);

	kprng_pkg::state_t state_q;

	logic [7:0]  step_q;
	logic [7:0]  d_q;
	logic [31:0] acc_q;
	logic [31:0] rc_q;
	logic        started_q;
	logic [7:0]  cnt_q;
	logic        m_valid_q;
	logic        rs_v_s1;

	logic [7:0]  rs_addr_s1;
	logic [31:0] key_q, lacc_q, macc_q;
	logic [31:0] m6_q, li_q, o_q, a_q, w_q, hash_q;
	logic [31:0] res_word_q, res_rc_q;
	logic        res_flag_q;
	logic [63:0] out_data_q;
	logic        out_flag_q;

	logic        l_we, m_we;
	logic [7:0]  l_waddr, m_waddr, l_raddr, m_raddr;
	logic [31:0] l_wdata, m_wdata, l_rdata, m_rdata;

	logic        in_acc;
	logic        out_free;
	logic [31:0] o_c, a_c, b_c, w_c, rs_x, hash_c;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == kprng_pkg::ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_flag_q;

	// step arithmetic
	assign o_c = (m6_q << 6) ^ (m_rdata << 7);
	assign a_c = ({24'd0, d_q} ^ o_c) ^ (rc_q + acc_q);
	assign b_c = (rc_q + a_q) ^ (o_q + {24'd0, d_q});
	assign w_c = kprng_pkg::rotl((a_q >> 13) ^ a_q, b_c[4:0]);

	// reseed: hash folds entry j in at shift j/32
	assign rs_x   = m_rdata ^ l_rdata;
	assign hash_c = hash_q ^ (rs_x << rs_addr_s1[7:5]);

	always_comb begin
		l_we    = 1'b0;
		m_we    = 1'b0;
		l_waddr = cnt_q;
		m_waddr = cnt_q;
		l_wdata = kprng_pkg::rotl(lacc_q, key_q[4:0] ^ cnt_q[4:0]);
		m_wdata = kprng_pkg::rotl(macc_q, key_q[4:0] ^ cnt_q[4:0]);
		l_raddr = cnt_q;
		m_raddr = cnt_q;
		case (state_q)
			kprng_pkg::ST_FILL: begin
				l_we = 1'b1;
				m_we = 1'b1;
			end
			kprng_pkg::ST_RD6: begin
				l_raddr = step_q;
				m_raddr = step_q + 8'd6;
			end
			kprng_pkg::ST_RD7: begin
				m_raddr = step_q + 8'd7;
			end
			kprng_pkg::ST_WORD: begin
				l_raddr = w_c[7:0];
			end
			kprng_pkg::ST_SWAP: begin
				l_we    = 1'b1;
				l_waddr = step_q;
				l_wdata = l_rdata;
			end
			kprng_pkg::ST_SWAP2: begin
				l_we    = 1'b1;
				l_waddr = w_q[7:0];
				l_wdata = li_q;
			end
			kprng_pkg::ST_RSEED, kprng_pkg::ST_RSLAST: begin
				m_we    = rs_v_s1;
				m_waddr = rs_addr_s1;
				m_wdata = rs_x;
			end
			default: begin
			end
		endcase
	end

	kprng_ram #(.WIDTH(32), .DEPTH(256)) u_l_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	kprng_ram #(.WIDTH(32), .DEPTH(256)) u_m_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kprng_pkg::ST_IDLE;
			step_q    <= kprng_pkg::STEP_FIRST;
			d_q       <= '0;
			acc_q     <= '0;
			rc_q      <= '0;
			started_q <= 1'b0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
			rs_v_s1   <= 1'b0;
		end else begin
			// output register: loaded in ST_OUT, cleared once taken
			if (state_q == kprng_pkg::ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			rs_v_s1 <= (state_q == kprng_pkg::ST_RSEED);
			case (state_q)
				kprng_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser == kprng_pkg::CMD_START) begin
							state_q <= kprng_pkg::ST_FILL0;
						end else if (started_q) begin
							state_q <= kprng_pkg::ST_RD6;
						end else begin
							state_q <= kprng_pkg::ST_OUT;
						end
					end
				end
				kprng_pkg::ST_FILL0: begin
					cnt_q   <= '0;
					state_q <= kprng_pkg::ST_FILL;
				end
				kprng_pkg::ST_FILL: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'd255) begin
						rc_q      <= key_q;
						acc_q     <= key_q;
						d_q       <= '0;
						step_q    <= kprng_pkg::STEP_FIRST;
						started_q <= 1'b1;
						state_q   <= kprng_pkg::ST_OUT;
					end
				end
				kprng_pkg::ST_RD6:  state_q <= kprng_pkg::ST_RD7;
				kprng_pkg::ST_RD7:  state_q <= kprng_pkg::ST_MIX;
				kprng_pkg::ST_MIX:  state_q <= kprng_pkg::ST_WORD;
				kprng_pkg::ST_WORD: state_q <= kprng_pkg::ST_SWAP;
				kprng_pkg::ST_SWAP: state_q <= kprng_pkg::ST_SWAP2;
				kprng_pkg::ST_SWAP2: begin
					acc_q <= a_q;
					d_q   <= w_q[7:0];
					// last step of a pass (a zero index is treated the same)
					if (step_q <= 8'd1) begin
						cnt_q   <= '0;
						state_q <= kprng_pkg::ST_RSEED;
					end else begin
						step_q  <= step_q - 8'd1;
						state_q <= kprng_pkg::ST_OUT;
					end
				end
				kprng_pkg::ST_RSEED: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'd255) begin
						state_q <= kprng_pkg::ST_RSLAST;
					end
				end
				kprng_pkg::ST_RSLAST: begin
					rc_q    <= hash_c;
					acc_q   <= hash_c;
					d_q     <= '0;
					step_q  <= kprng_pkg::STEP_FIRST;
					state_q <= kprng_pkg::ST_OUT;
				end
				kprng_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= kprng_pkg::ST_IDLE;
					end
				end
				default: state_q <= kprng_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rs_addr_s1 <= cnt_q;
		case (state_q)
			kprng_pkg::ST_IDLE: begin
				if (in_acc) begin
					key_q      <= s_axis_tdata;
					res_word_q <= '0;
					res_flag_q <= 1'b0;
					res_rc_q   <= (s_axis_tuser == kprng_pkg::CMD_START) ? s_axis_tdata : rc_q;
				end
			end
			kprng_pkg::ST_FILL0: begin
				lacc_q <= key_q * kprng_pkg::L_MUL;
				macc_q <= key_q * kprng_pkg::M_MUL;
			end
			kprng_pkg::ST_FILL: begin
				lacc_q <= lacc_q + kprng_pkg::L_MUL;
				macc_q <= macc_q + kprng_pkg::M_MUL;
			end
			kprng_pkg::ST_RD7: begin
				m6_q <= m_rdata;
				li_q <= l_rdata;
			end
			kprng_pkg::ST_MIX: begin
				o_q <= o_c;
				a_q <= a_c;
			end
			kprng_pkg::ST_WORD: begin
				w_q <= w_c;
			end
			kprng_pkg::ST_SWAP2: begin
				res_word_q <= w_q;
				res_flag_q <= 1'b1;
				res_rc_q   <= rc_q;
				hash_q     <= '0;
			end
			kprng_pkg::ST_RSEED: begin
				if (rs_v_s1) begin
					hash_q <= hash_c;
				end
			end
			kprng_pkg::ST_OUT: begin
				if (out_free) begin
					out_data_q <= {res_rc_q, res_word_q};
					out_flag_q <= res_flag_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_idle_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
		else $error("non-word result carries a nonzero word");

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> step_q != 8'd0)
		else $error("step index reached zero");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q != kprng_pkg::ST_IDLE)
		else $error("accepted word did not start work");

	a_word_started: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> started_q)
		else $error("generated word before any start");
`endif

endmodule

// ===== rtl/kprng_ram.sv =====
module kprng_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== bench/keyed_permutation_prng_stream_test.sv =====
`timescale 1ns / 100ps

module keyed_permutation_prng_stream_test;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int TARGET_ITEMS  = 1400;
	localparam int TAIL_CYCLES   = 300;
	localparam int HOLD_PERIOD   = 7000;
	localparam int HOLD_LENGTH   = 600;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [31:0] word;
		logic [31:0] round_constant;
		logic        word_valid;
	} prng_result_t;

	// Bit-true predictor of the generator plus the queue of words it expects.
	class prng_word_model;
		logic [31:0] perm [kprng_pkg::TBL_DEPTH];
		logic [31:0] mix [kprng_pkg::TBL_DEPTH];
		logic [31:0] run_constant;
		logic [31:0] acc_a;
		logic [7:0]  last_low_byte;
		logic [7:0]  step_index;
		logic        started;
		prng_result_t expected_words [$];
		int mismatches;
		int starts;
		int words;
		int ignored;
		int reseeds;

		function new();
			run_constant = '0;
			acc_a = '0;
			last_low_byte = '0;
			step_index = kprng_pkg::STEP_FIRST;
			started = 1'b0;
			mismatches = 0;
			starts = 0;
			words = 0;
			ignored = 0;
			reseeds = 0;
		endfunction

		function logic [31:0] rotate_left(logic [31:0] v, logic [4:0] amt);
			if (amt == 5'd0)
				return v;
			return (v << amt) | (v >> (6'd32 - amt));
		endfunction

		function logic [31:0] fold_mix();
			logic [31:0] acc;
			logic [31:0] h;
			acc = '0;
			for (int j = 0; j < kprng_pkg::TBL_DEPTH; j++)
				mix[j] = mix[j] ^ perm[j];
			for (int e = 0; e < 8; e++) begin
				h = '0;
				for (int j = 0; j < 32; j++)
					h = h ^ mix[e * 32 + j];
				acc = acc ^ (h << e);
			end
			return acc;
		endfunction

		function void note_command(logic cmd, logic [31:0] key);
			prng_result_t r;
			logic [31:0] idx;
			logic [31:0] o;
			logic [31:0] a;
			logic [31:0] b;
			logic [31:0] w;
			logic [31:0] t;
			logic [7:0]  i;
			logic [7:0]  nd;
			if (cmd == kprng_pkg::CMD_START) begin
				for (int k = 0; k < kprng_pkg::TBL_DEPTH; k++) begin
					idx = k;
					perm[k] = rotate_left(idx * kprng_pkg::L_MUL + kprng_pkg::L_MUL * key,
						key[4:0] ^ idx[4:0]);
					mix[k] = rotate_left(idx * kprng_pkg::M_MUL + kprng_pkg::M_MUL * key,
						key[4:0] ^ idx[4:0]);
				end
				run_constant = key;
				acc_a = key;
				last_low_byte = '0;
				step_index = kprng_pkg::STEP_FIRST;
				started = 1'b1;
				r = '{word: '0, round_constant: key, word_valid: 1'b0};
				starts++;
			end else if (!started) begin
				r = '{word: '0, round_constant: run_constant, word_valid: 1'b0};
				ignored++;
			end else begin
				i = step_index;
				o = (mix[i + 8'd6] << 6) ^ (mix[i + 8'd7] << 7);
				a = ({24'd0, last_low_byte} ^ o) ^ (run_constant + acc_a);
				b = (run_constant + a) ^ (o + {24'd0, last_low_byte});
				w = rotate_left((a >> 13) ^ a, b[4:0]);
				nd = w[7:0];
				t = perm[i];
				perm[i] = perm[nd];
				perm[nd] = t;
				acc_a = a;
				last_low_byte = nd;
				r = '{word: w, round_constant: run_constant, word_valid: 1'b1};
				words++;
				// step 1 closes the pass: fold L into M and restart the walk
				if (i <= 8'd1) begin
					run_constant = fold_mix();
					acc_a = run_constant;
					last_low_byte = '0;
					step_index = kprng_pkg::STEP_FIRST;
					reseeds++;
				end else begin
					step_index = i - 8'd1;
				end
			end
			expected_words.push_back(r);
		endfunction

		function void check_word(logic [31:0] w, logic [31:0] rc, logic v);
			prng_result_t e;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected word %h rc %h valid %b", w, rc, v);
				return;
			end
			e = expected_words.pop_front();
			if (e.word !== w || e.round_constant !== rc || e.word_valid !== v) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("word mismatch: exp %h/%h/%b got %h/%h/%b",
						e.word, e.round_constant, e.word_valid, w, rc, v);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;

	prng_word_model model = new();
	int cycle_count = 0;
	int sent = 0;
	int burst_left = 0;
	int holds = 0;

	keyed_permutation_prng_stream uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words pending", cycle_count,
				model.pending());
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				model.note_command(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				model.check_word(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
		end
	end

	// receiver: changing stall pattern, plus a long hold-off every so often
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int phase;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		phase = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			phase++;
			if (phase % HOLD_PERIOD == HOLD_PERIOD / 2) begin
				hold_left = HOLD_LENGTH;
				holds++;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = ($urandom_range(0, 9) < 6);
					2: m_axis_tready = (phase % 4 == 0);
					default: m_axis_tready = ($urandom_range(0, 9) < 2);
				endcase
			end
		end
	end

	task automatic send_cmd(logic cmd, logic [31:0] key);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tuser = cmd;
		s_axis_tdata = key;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain_words();
		s_axis_tvalid = 1'b0;
		while (model.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'd1 << $urandom_range(0, 31);
			3: return ~(32'd1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int run_len;
		int pick;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = kprng_pkg::CMD_START;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// next before any start is ignored
		send_cmd(kprng_pkg::CMD_NEXT, 32'hFFFF_FFFF);
		send_cmd(kprng_pkg::CMD_NEXT, 32'h0000_0000);
		send_cmd(kprng_pkg::CMD_START, 32'h0000_0000);
		repeat (3) send_cmd(kprng_pkg::CMD_NEXT, $urandom);
		send_cmd(kprng_pkg::CMD_START, 32'hFFFF_FFFF);
		repeat (3) send_cmd(kprng_pkg::CMD_NEXT, 32'h0000_0000);
		send_cmd(kprng_pkg::CMD_START, 32'h8000_0001);
		repeat (2) send_cmd(kprng_pkg::CMD_NEXT, 32'hFFFF_FFFF);
		// back-to-back starts reinitialise while running
		send_cmd(kprng_pkg::CMD_START, 32'h0000_001F);
		send_cmd(kprng_pkg::CMD_START, 32'h1234_5678);
		repeat (2) send_cmd(kprng_pkg::CMD_NEXT, $urandom);
		drain_words();

		// two full passes, crossing the reseed twice
		send_cmd(kprng_pkg::CMD_START, pick_key());
		repeat (520) send_cmd(kprng_pkg::CMD_NEXT, $urandom);

		while (sent < TARGET_ITEMS) begin
			send_cmd(kprng_pkg::CMD_START, pick_key());
			pick = $urandom_range(0, 9);
			if (pick < 6)
				run_len = $urandom_range(1, 40);
			else if (pick < 9)
				run_len = $urandom_range(41, 260);
			else
				run_len = $urandom_range(261, 520);
			for (int k = 0; k < run_len && sent < TARGET_ITEMS; k++)
				send_cmd(kprng_pkg::CMD_NEXT, $urandom);
			if ($urandom_range(0, 5) == 0)
				drain_words();
		end

		drain_words();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("%0d commands: %0d starts, %0d words, %0d ignored nexts, %0d reseeds",
			sent, model.starts, model.words, model.ignored, model.reseeds);
		$display("%0d long output hold-offs, %0d cycles, %0d mismatches",
			holds, cycle_count, model.mismatches);
		if (model.mismatches == 0 && model.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/kprng_pkg.sv
rtl/kprng_ram.sv
rtl/keyed_permutation_prng_stream.sv
bench/keyed_permutation_prng_stream_test.sv
